// File: rtl/threshold_rule_monitor_top_assert.svh
// Assertion macros for the rule monitor top level.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef THRESHOLD_RULE_MONITOR_TOP_ASSERT_SVH
`define THRESHOLD_RULE_MONITOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TRM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define TRM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/trm_pkg.sv
package trm_pkg;

   // Request kinds.
   localparam logic KIND_EVAL  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Comparison codes; the two highest codes never compare true.
   localparam logic [2:0] CMP_GT = 3'd0;
   localparam logic [2:0] CMP_LT = 3'd1;
   localparam logic [2:0] CMP_GE = 3'd2;
   localparam logic [2:0] CMP_LE = 3'd3;
   localparam logic [2:0] CMP_EQ = 3'd4;
   localparam logic [2:0] CMP_NE = 3'd5;

   // Action codes; the unused fourth code acts as an alert.
   localparam logic [1:0] ACT_MACRO = 2'd0;
   localparam logic [1:0] ACT_LOG   = 2'd1;
   localparam logic [1:0] ACT_ALERT = 2'd2;

   // Register byte address of the global enable.
   localparam logic CSR_RULES_ON_ADDR = 1'b0;

   // Static part of one rule, written by write requests only.
   typedef struct packed {
      logic [2:0]  compare;
      logic [15:0] threshold;
      logic [31:0] hold_ms;
      logic [31:0] cooldown_ms;
      logic [1:0]  action;
      logic [7:0]  macro_num;
   } rule_cfg_type;

   // Timing part of one rule, updated by evaluate requests.
   typedef struct packed {
      logic [31:0] true_since;
      logic [31:0] last_fire;
   } rule_time_type;

endpackage

// File: rtl/threshold_rule_monitor_top.sv
// Rule monitor: a request is taken when start is high and busy is low. In the cycle
// after acceptance busy is high while the rule entry, read from the rule and timing
// memories, is compared and its timing written back. The result then shows on the rsp_
// ports for exactly one cycle, marked by rsp_valid, and cannot be held off, so the
// receiver must take it in that cycle. Every request, write or evaluate, gives exactly
// one result. Rule writes take effect at acceptance. No clearing pass runs after reset:
// per-rule valid bits stand in for cleared entries.
`include "threshold_rule_monitor_top_assert.svh"

module threshold_rule_monitor_top
   import trm_pkg::*;
#(
   parameter int NUM_RULES = 8
) (
   input  logic               clock,
   input  logic               reset,
   // Request channel.
   input  logic               start,
   output logic               busy,
   input  logic               req_kind,
   input  logic [2:0]         req_rule_index,
   input  logic signed [15:0] req_sample_value,
   input  logic [31:0]        req_now_ms,
   input  logic               req_new_enable,
   input  logic [2:0]         req_new_compare,
   input  logic signed [15:0] req_new_threshold,
   input  logic [31:0]        req_new_hold_ms,
   input  logic [31:0]        req_new_cooldown_ms,
   input  logic [1:0]         req_new_action,
   input  logic [7:0]         req_new_action_arg,
   // Result channel.
   output logic               rsp_valid,
   output logic               rsp_fired,
   output logic [2:0]         rsp_fired_rule,
   output logic signed [15:0] rsp_fired_value,
   output logic [1:0]         rsp_action_kind,
   output logic [7:0]         rsp_action_value,
   output logic [31:0]        rsp_total_fires,
   // Configuration port.
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int AW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;

   // Memories and per-entry flags.
   rule_cfg_type            cfg_mem  [NUM_RULES];
   rule_time_type           time_mem [NUM_RULES];
   logic [NUM_RULES-1:0]    enabled_ff;
   logic [NUM_RULES-1:0]    time_vld_ff;

   // Control registers.
   logic                    rules_on_ff;
   logic [31:0]             fire_cnt_ff, fire_cnt_in;

   // Stage one: request held while its entry is read.
   logic                    s1_valid_ff;
   logic                    s1_kind_ff;
   logic [2:0]              s1_index_ff;
   logic [AW-1:0]           s1_addr_ff;
   logic                    s1_in_range_ff;
   logic                    s1_enabled_ff;
   logic                    s1_time_vld_ff;
   logic signed [15:0]      s1_sample_ff;
   logic [31:0]             s1_now_ms_ff;
   rule_cfg_type            cfg_rd_ff;
   rule_time_type           time_rd_ff;

   // Result registers.
   logic                    rsp_valid_ff;
   logic                    rsp_fired_ff, rsp_fired_in;
   logic [2:0]              rsp_rule_ff;
   logic signed [15:0]      rsp_value_ff, rsp_value_in;
   logic [1:0]              rsp_action_ff, rsp_action_in;
   logic [7:0]              rsp_macro_ff, rsp_macro_in;

   logic                    accept;
   logic [AW-1:0]           req_addr;
   logic                    req_in_range;
   rule_cfg_type            new_cfg;

   logic                    active;
   logic                    cond_true;
   logic [31:0]             since_old;
   logic [31:0]             last_old;
   logic [31:0]             since_new;
   logic                    hold_ok;
   logic                    cool_ok;
   logic                    fire;
   rule_time_type           time_wr;

   logic                    csr_wr;

   // Request acceptance and address decode.
   assign busy         = s1_valid_ff;
   assign accept       = start && !s1_valid_ff;
   assign req_addr     = AW'(req_rule_index);
   assign req_in_range = (32'(req_rule_index) < NUM_RULES);

   // Entry to store on a write request, with the unused action code folded to alert.
   always_comb begin
      new_cfg.compare     = req_new_compare;
      new_cfg.threshold   = req_new_threshold;
      new_cfg.hold_ms     = req_new_hold_ms;
      new_cfg.cooldown_ms = req_new_cooldown_ms;
      new_cfg.action      = (req_new_action > ACT_ALERT) ? ACT_ALERT : req_new_action;
      new_cfg.macro_num   = req_new_action_arg;
   end

   // Rule memory: written and read at acceptance.
   always_ff @(posedge clock) begin
      if (accept && req_kind == KIND_WRITE && req_in_range) begin
         cfg_mem[req_addr] <= new_cfg;
      end
      if (accept) begin
         cfg_rd_ff <= cfg_mem[req_addr];
      end
   end

   // Timing memory: read at acceptance, written back from stage one.
   always_ff @(posedge clock) begin
      if (active) begin
         time_mem[s1_addr_ff] <= time_wr;
      end
      if (accept) begin
         time_rd_ff <= time_mem[req_addr];
      end
   end

   // Enable flags and timing valid flags, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= '0;
         time_vld_ff <= '0;
      end else begin
         if (accept && req_kind == KIND_WRITE && req_in_range) begin
            enabled_ff[req_addr] <= req_new_enable;
         end
         if (active) begin
            time_vld_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   // Stage one control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   // Stage one payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff     <= req_kind;
         s1_index_ff    <= req_rule_index;
         s1_addr_ff     <= req_addr;
         s1_in_range_ff <= req_in_range;
         s1_enabled_ff  <= req_in_range && enabled_ff[req_addr];
         s1_time_vld_ff <= req_in_range && time_vld_ff[req_addr];
         s1_sample_ff   <= req_sample_value;
         s1_now_ms_ff   <= req_now_ms;
      end
   end

   // Comparison of the sample against the stored threshold.
   always_comb begin
      case (cfg_rd_ff.compare)
         CMP_GT:  cond_true = s1_sample_ff >  $signed(cfg_rd_ff.threshold);
         CMP_LT:  cond_true = s1_sample_ff <  $signed(cfg_rd_ff.threshold);
         CMP_GE:  cond_true = s1_sample_ff >= $signed(cfg_rd_ff.threshold);
         CMP_LE:  cond_true = s1_sample_ff <= $signed(cfg_rd_ff.threshold);
         CMP_EQ:  cond_true = s1_sample_ff == $signed(cfg_rd_ff.threshold);
         CMP_NE:  cond_true = s1_sample_ff != $signed(cfg_rd_ff.threshold);
         default: cond_true = 1'b0;
      endcase
   end

   // Hold and cooldown checks; time differences wrap at 32 bits.
   always_comb begin
      active    = s1_valid_ff && s1_kind_ff == KIND_EVAL && s1_in_range_ff
                  && rules_on_ff && s1_enabled_ff;
      since_old = s1_time_vld_ff ? time_rd_ff.true_since : 32'd0;
      last_old  = s1_time_vld_ff ? time_rd_ff.last_fire : 32'd0;
      since_new = (since_old == 32'd0) ? s1_now_ms_ff : since_old;
      hold_ok   = (cfg_rd_ff.hold_ms == 32'd0)
                  || ((s1_now_ms_ff - since_new) >= cfg_rd_ff.hold_ms);
      cool_ok   = (s1_now_ms_ff - last_old) >= cfg_rd_ff.cooldown_ms;
      fire      = active && cond_true && hold_ok && cool_ok;

      time_wr.true_since = cond_true ? since_new : 32'd0;
      time_wr.last_fire  = fire ? s1_now_ms_ff : last_old;

      fire_cnt_in   = fire ? fire_cnt_ff + 32'd1 : fire_cnt_ff;
      rsp_fired_in  = fire;
      rsp_value_in  = fire ? s1_sample_ff : 16'sd0;
      rsp_action_in = fire ? cfg_rd_ff.action : ACT_MACRO;
      rsp_macro_in  = fire ? cfg_rd_ff.macro_num : 8'd0;
   end

   // Fire counter and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         fire_cnt_ff  <= 32'd0;
         rsp_valid_ff <= 1'b0;
         rsp_fired_ff <= 1'b0;
      end else begin
         fire_cnt_ff  <= fire_cnt_in;
         rsp_valid_ff <= s1_valid_ff;
         rsp_fired_ff <= rsp_fired_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_rule_ff   <= s1_index_ff;
         rsp_value_ff  <= rsp_value_in;
         rsp_action_ff <= rsp_action_in;
         rsp_macro_ff  <= rsp_macro_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fired        = rsp_fired_ff;
   assign rsp_fired_rule   = rsp_rule_ff;
   assign rsp_fired_value  = rsp_value_ff;
   assign rsp_action_kind  = rsp_action_ff;
   assign rsp_action_value = rsp_macro_ff;
   assign rsp_total_fires  = fire_cnt_ff;

   // Configuration register.
   assign csr_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign prdata = (paddr == CSR_RULES_ON_ADDR) ? {31'd0, rules_on_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rules_on_ff <= 1'b0;
      end else if (csr_wr && paddr == CSR_RULES_ON_ADDR) begin
         rules_on_ff <= pwdata[0];
      end
   end

   // Checks on the request flow and the fire counter.
   `TRM_ASSERT_NEXT(a_busy_one_cycle, busy, !busy, "busy held longer than one cycle")
   `TRM_ASSERT_NOW(a_rsp_after_busy, rsp_valid, $past(busy), "result without a request")
   `TRM_ASSERT_NOW(a_fired_strobed, rsp_fired, rsp_valid, "fire flag outside a result")
   `TRM_ASSERT_NOW(a_count_step, rsp_fired, fire_cnt_ff == $past(fire_cnt_ff) + 32'd1,
      "fire counter did not advance on a firing")

endmodule

// File: verif/threshold_rule_monitor_top_tb.sv
module threshold_rule_monitor_top_tb
   import trm_pkg::*;
();

   // Comparison and action codes that the package leaves unnamed.
   localparam logic [2:0] CMP_UNUSED_LO = 3'd6;
   localparam logic [2:0] CMP_UNUSED_HI = 3'd7;
   localparam logic [1:0] ACT_UNUSED    = 2'd3;
   localparam int         RULE_COUNT    = 8;
   localparam int         QUIET_LIMIT   = 500;
   localparam int         PHASE_ITEMS   = 240;

   typedef struct {
      logic               kind;
      logic [2:0]         idx;
      logic signed [15:0] sample;
      logic [31:0]        now;
      logic               en;
      logic [2:0]         cmp;
      logic signed [15:0] thr;
      logic [31:0]        hold;
      logic [31:0]        cooldown;
      logic [1:0]         act;
      logic [7:0]         arg;
   } rule_request_type;

   typedef struct {
      logic               fired;
      logic [2:0]         rule_idx;
      logic signed [15:0] value;
      logic [1:0]         act_kind;
      logic [7:0]         act_arg;
      logic [31:0]        total;
   } alarm_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_kind = 1'b0;
   logic [2:0]         req_rule_index = '0;
   logic signed [15:0] req_sample_value = '0;
   logic [31:0]        req_now_ms = '0;
   logic               req_new_enable = 1'b0;
   logic [2:0]         req_new_compare = '0;
   logic signed [15:0] req_new_threshold = '0;
   logic [31:0]        req_new_hold_ms = '0;
   logic [31:0]        req_new_cooldown_ms = '0;
   logic [1:0]         req_new_action = '0;
   logic [7:0]         req_new_action_arg = '0;
   logic               rsp_valid;
   logic               rsp_fired;
   logic [2:0]         rsp_fired_rule;
   logic signed [15:0] rsp_fired_value;
   logic [1:0]         rsp_action_kind;
   logic [7:0]         rsp_action_value;
   logic [31:0]        rsp_total_fires;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic               paddr = 1'b0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   threshold_rule_monitor_top i_dut (.*);

   // Stimulus and bookkeeping.
   rule_request_type request_backlog[$];
   alarm_type        pending_alarms[$];
   rule_request_type launch;
   int            queued_total = 0;
   int            accepted_total = 0;
   int            write_total = 0;
   int            eval_total = 0;
   int            fire_seen = 0;
   int            csr_writes = 0;
   int            mismatch_count = 0;
   int            gap_left = 0;
   int            quiet_cycles = 0;
   bit            no_gaps = 1'b0;
   logic          req_taken = 1'b0;

   // Predictor copy of the rule table.
   logic               enable_mirror;
   logic               rule_en[RULE_COUNT];
   logic [2:0]         rule_cmp[RULE_COUNT];
   logic signed [15:0] rule_thr[RULE_COUNT];
   logic [31:0]        rule_hold[RULE_COUNT];
   logic [31:0]        rule_cd[RULE_COUNT];
   logic [1:0]         rule_act[RULE_COUNT];
   logic [7:0]         rule_arg[RULE_COUNT];
   logic [31:0]        true_since[RULE_COUNT];
   logic [31:0]        last_fire[RULE_COUNT];
   logic [31:0]        fire_total;

   // Generator state: time base and the thresholds last written per rule.
   logic [31:0]        clock_ms = 32'd1;
   logic signed [15:0] shadow_thr[RULE_COUNT];

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
      mismatch_count++;
   endtask

   function automatic bit compare_holds(logic signed [15:0] a, logic [2:0] op,
                                        logic signed [15:0] b);
      case (op)
         CMP_GT: return a > b;
         CMP_LT: return a < b;
         CMP_GE: return a >= b;
         CMP_LE: return a <= b;
         CMP_EQ: return a == b;
         CMP_NE: return a != b;
         default: return 1'b0;
      endcase
   endfunction

   // Applies one accepted request to the rule table and returns its alarm report.
   function automatic alarm_type apply_rule_request(rule_request_type r);
      alarm_type   a;
      logic [31:0] since_start;
      logic [31:0] since_fire;
      a = '{fired: 1'b0, rule_idx: r.idx, value: '0, act_kind: '0, act_arg: '0,
            total: '0};
      if (r.kind == KIND_WRITE) begin
         rule_en[r.idx]   = r.en;
         rule_cmp[r.idx]  = r.cmp;
         rule_thr[r.idx]  = r.thr;
         rule_hold[r.idx] = r.hold;
         rule_cd[r.idx]   = r.cooldown;
         rule_act[r.idx]  = (r.act > ACT_ALERT) ? ACT_ALERT : r.act;
         rule_arg[r.idx]  = r.arg;
      end else if (enable_mirror && rule_en[r.idx]) begin
         if (!compare_holds(r.sample, rule_cmp[r.idx], rule_thr[r.idx])) begin
            true_since[r.idx] = '0;
         end else begin
            // A start time of zero means unset, so it is taken up again.
            if (true_since[r.idx] == 0) true_since[r.idx] = r.now;
            since_start = r.now - true_since[r.idx];
            since_fire  = r.now - last_fire[r.idx];
            if (!(rule_hold[r.idx] != 0 && since_start < rule_hold[r.idx]) &&
                since_fire >= rule_cd[r.idx]) begin
               last_fire[r.idx] = r.now;
               fire_total       = fire_total + 32'd1;
               a.fired    = 1'b1;
               a.value    = r.sample;
               a.act_kind = rule_act[r.idx];
               a.act_arg  = rule_arg[r.idx];
            end
         end
      end
      a.total = fire_total;
      return a;
   endfunction

   // Request builders; the fields that the kind ignores carry random values.
   function automatic rule_request_type make_write(int idx, bit en, logic [2:0] cmp,
                                                   logic signed [15:0] thr,
                                                   logic [31:0] hold, logic [31:0] cd,
                                                   logic [1:0] act, logic [7:0] arg);
      rule_request_type r;
      r.kind = KIND_WRITE;
      r.idx = idx[2:0];
      r.sample = 16'($urandom_range(0, 65535));
      r.now = $urandom;
      r.en = en;
      r.cmp = cmp;
      r.thr = thr;
      r.hold = hold;
      r.cooldown = cd;
      r.act = act;
      r.arg = arg;
      return r;
   endfunction

   function automatic rule_request_type make_eval(int idx, logic signed [15:0] sample,
                                                  logic [31:0] now);
      rule_request_type r;
      r.kind = KIND_EVAL;
      r.idx = idx[2:0];
      r.sample = sample;
      r.now = now;
      r.en = 1'($urandom_range(0, 1));
      r.cmp = 3'($urandom_range(0, 7));
      r.thr = 16'($urandom_range(0, 65535));
      r.hold = $urandom;
      r.cooldown = $urandom;
      r.act = 2'($urandom_range(0, 3));
      r.arg = 8'($urandom_range(0, 255));
      return r;
   endfunction

   task automatic queue_request(rule_request_type r);
      request_backlog.push_back(r);
      queued_total++;
   endtask

   // A sample at most two steps from the threshold, kept in range.
   function automatic logic signed [15:0] near_threshold(logic signed [15:0] thr);
      int t;
      t = int'(thr);
      t = t + int'($urandom_range(0, 4)) - 2;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return 16'(t);
   endfunction

   function automatic logic signed [15:0] pick_threshold();
      case ($urandom_range(0, 9))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         default: return 16'(int'($urandom_range(0, 400)) - 200);
      endcase
   endfunction

   // One random request: mostly rule writes and evaluations along a running time
   // base, with some fully random noise.
   task automatic queue_random_request();
      rule_request_type r;
      int            sel;
      int            idx;
      logic [2:0]    cmp;
      logic [31:0]   hold;
      logic [31:0]   cd;
      logic signed [15:0] thr;
      logic signed [15:0] sample;
      sel = $urandom_range(0, 99);
      idx = $urandom_range(0, RULE_COUNT - 1);
      if (sel < 12) begin
         cmp = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 5))
                                          : 3'($urandom_range(6, 7));
         case ($urandom_range(0, 9))
            0, 1, 2, 3: hold = '0;
            9: hold = $urandom;
            default: hold = $urandom_range(1, 60);
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3: cd = '0;
            9: cd = $urandom;
            default: cd = $urandom_range(1, 80);
         endcase
         thr = pick_threshold();
         shadow_thr[idx] = thr;
         r = make_write(idx, $urandom_range(0, 7) != 0, cmp, thr, hold, cd,
                        2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else if (sel < 92) begin
         if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
         else clock_ms = clock_ms + $urandom_range(0, 40);
         case ($urandom_range(0, 19))
            0: sample = -16'sd32768;
            1: sample = 16'sd32767;
            2, 3, 4: sample = 16'($urandom_range(0, 65535));
            default: sample = near_threshold(shadow_thr[idx]);
         endcase
         r = make_eval(idx, sample, clock_ms);
      end else begin
         r = make_eval(idx, 16'($urandom_range(0, 65535)), $urandom);
         r.kind = 1'($urandom_range(0, 1));
         if (r.kind == KIND_WRITE) shadow_thr[idx] = r.thr;
      end
      queue_request(r);
   endtask

   // Waits until every queued request is taken and every alarm report is back.
   task automatic wait_until_idle();
      do @(negedge clock);
      while (accepted_total != queued_total || pending_alarms.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_RULES_ON_ADDR;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      csr_writes++;
   endtask

   task automatic csr_read_check(input logic want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_RULES_ON_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[0] !== want) flag_mismatch("rules_on readback", prdata, 32'(want));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_rules_on(input logic value);
      csr_write({31'($urandom), value});
      @(negedge clock);
      csr_read_check(value);
      @(negedge clock);
   endtask

   // Request driver: holds each request until it is taken, then waits its gap.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (gap_left != 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (request_backlog.size() != 0) begin
            launch = request_backlog.pop_front();
            req_kind            <= launch.kind;
            req_rule_index      <= launch.idx;
            req_sample_value    <= launch.sample;
            req_now_ms          <= launch.now;
            req_new_enable      <= launch.en;
            req_new_compare     <= launch.cmp;
            req_new_threshold   <= launch.thr;
            req_new_hold_ms     <= launch.hold;
            req_new_cooldown_ms <= launch.cooldown;
            req_new_action      <= launch.act;
            req_new_action_arg  <= launch.arg;
            start <= 1'b1;
            gap_left <= no_gaps ? 0 : $urandom_range(0, 9);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: predicts on request acceptance and checks each alarm report.
   always @(posedge clock) begin
      alarm_type        want;
      rule_request_type seen;
      if (reset) begin
         req_taken <= 1'b0;
         enable_mirror = 1'b0;
         fire_total = '0;
         for (int i = 0; i < RULE_COUNT; i++) begin
            rule_en[i] = 1'b0;
            true_since[i] = '0;
            last_fire[i] = '0;
         end
      end else begin
         req_taken <= start && !busy;
         if (psel && penable && pwrite && pready && paddr == CSR_RULES_ON_ADDR)
            enable_mirror = pwdata[0];
         if (start && !busy) begin
            seen = '{kind: req_kind, idx: req_rule_index, sample: req_sample_value,
                     now: req_now_ms, en: req_new_enable, cmp: req_new_compare,
                     thr: req_new_threshold, hold: req_new_hold_ms,
                     cooldown: req_new_cooldown_ms, act: req_new_action,
                     arg: req_new_action_arg};
            pending_alarms.push_back(apply_rule_request(seen));
            accepted_total++;
            if (req_kind == KIND_WRITE) write_total++;
            else eval_total++;
         end
         if (rsp_valid) begin
            if (pending_alarms.size() == 0) begin
               flag_mismatch("report with no request outstanding",
                             32'(rsp_fired_rule), 32'd0);
            end else begin
               want = pending_alarms.pop_front();
               if (rsp_fired !== want.fired)
                  flag_mismatch("fired", 32'(rsp_fired), 32'(want.fired));
               if (rsp_fired_rule !== want.rule_idx)
                  flag_mismatch("fired_rule", 32'(rsp_fired_rule), 32'(want.rule_idx));
               if (rsp_fired_value !== want.value)
                  flag_mismatch("fired_value", 32'(rsp_fired_value), 32'(want.value));
               if (rsp_action_kind !== want.act_kind)
                  flag_mismatch("action_kind", 32'(rsp_action_kind), 32'(want.act_kind));
               if (rsp_action_value !== want.act_arg)
                  flag_mismatch("action_value", 32'(rsp_action_value), 32'(want.act_arg));
               if (rsp_total_fires !== want.total)
                  flag_mismatch("total_fires", rsp_total_fires, want.total);
               if (want.fired) fire_seen++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake of any kind.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("timeout after %0d quiet cycles", QUIET_LIMIT);
         $display("threshold_rule_monitor_top_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < RULE_COUNT; i++) shadow_thr[i] = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Global enable off: evaluations change nothing, writes still land.
      set_rules_on(1'b0);
      queue_request(make_eval(5, 16'sd7, 32'd20));
      queue_request(make_write(0, 1'b1, CMP_GT, 16'sd100, 32'd0, 32'd0, ACT_UNUSED,
                               8'd255));
      queue_request(make_eval(0, 16'sd101, 32'd5));
      wait_until_idle();

      // Global enable on: every comparison, the threshold extremes, the unused
      // codes, the zero start time, a disabled rule and a maximal cooldown.
      set_rules_on(1'b1);
      queue_request(make_eval(7, -16'sd1, 32'd9));
      queue_request(make_eval(0, 16'sd101, 32'd10));
      queue_request(make_eval(0, 16'sd100, 32'd11));
      queue_request(make_write(1, 1'b1, CMP_LT, -16'sd32768, 32'd0, 32'd0, ACT_MACRO,
                               8'd0));
      queue_request(make_eval(1, -16'sd32768, 32'd12));
      queue_request(make_write(1, 1'b1, CMP_GE, 16'sd32767, 32'd0, 32'd0, ACT_LOG,
                               8'd17));
      queue_request(make_eval(1, 16'sd32767, 32'd13));
      queue_request(make_write(2, 1'b1, CMP_LE, -16'sd32768, 32'd0, 32'd4, ACT_ALERT,
                               8'd128));
      queue_request(make_eval(2, -16'sd32768, 32'd14));
      queue_request(make_eval(2, 16'sd0, 32'd15));
      queue_request(make_write(3, 1'b1, CMP_EQ, 16'sd0, 32'd5, 32'd0, ACT_MACRO,
                               8'd1));
      queue_request(make_eval(3, 16'sd0, 32'd0));
      queue_request(make_eval(3, 16'sd0, 32'd3));
      queue_request(make_eval(3, 16'sd0, 32'd8));
      queue_request(make_write(4, 1'b1, CMP_NE, 16'sd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               ACT_LOG, 8'd2));
      queue_request(make_eval(4, 16'sd6, 32'd100));
      queue_request(make_write(5, 1'b1, CMP_UNUSED_LO, 16'sd0, 32'd0, 32'd0,
                               ACT_ALERT, 8'd3));
      queue_request(make_eval(5, 16'sd0, 32'd101));
      queue_request(make_write(6, 1'b1, CMP_UNUSED_HI, 16'sd0, 32'd0, 32'd0,
                               ACT_MACRO, 8'd4));
      queue_request(make_eval(6, 16'sd0, 32'd102));
      queue_request(make_write(7, 1'b0, CMP_GE, -16'sd32768, 32'd0, 32'd0, ACT_LOG,
                               8'd5));
      queue_request(make_eval(7, 16'sd0, 32'd103));
      wait_until_idle();

      // Random phases; two run with the global enable off, one crosses the
      // 32-bit time wrap, and every third runs without gaps.
      clock_ms = 32'd200;
      for (int phase = 0; phase < 8; phase++) begin
         set_rules_on((phase == 2 || phase == 6) ? 1'b0 : 1'b1);
         no_gaps = (phase % 3 == 1);
         if (phase == 4) clock_ms = 32'hFFFF_FF00;
         for (int n = 0; n < PHASE_ITEMS; n++) queue_random_request();
         wait_until_idle();
      end

      repeat (8) @(negedge clock);
      if (pending_alarms.size() != 0)
         flag_mismatch("alarm reports never delivered", pending_alarms.size(), 32'd0);
      $display("Covered %0d requests: %0d rule writes and %0d evaluations, %0d firings.",
               accepted_total, write_total, eval_total, fire_seen);
      $display("Global enable written %0d times; final fire counter %0d.",
               csr_writes, fire_total);
      if (mismatch_count == 0) begin
         $display("threshold_rule_monitor_top_tb OK");
      end else begin
         $display("threshold_rule_monitor_top_tb NOT OK");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/trm_pkg.sv
rtl/threshold_rule_monitor_top.sv
verif/threshold_rule_monitor_top_tb.sv
